[hw/rtl/bls_pkg.sv]
// ----------------------------------------------------------------------------
// bls_pkg: shared types and codes for the bounded list block
// Operation and status codes, payload structs of both channels and the
// default store depth.
// ----------------------------------------------------------------------------
package bls_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 7;
    localparam int COUNT_W  = 7;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DROP_FRONT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DROP_BACK  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SEARCH     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SORT       = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SHORT     = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;
        logic signed [VALUE_W-1:0] key;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [COUNT_W-1:0]  count;
        logic                is_empty;
    } out_t;

endpackage

[hw/rtl/bounded_list_with_search_sort.sv]
// ----------------------------------------------------------------------------
// bounded_list_with_search_sort: bounded deque with linear search and sort
// Circular store of signed 32-bit values in one RAM, driven by a sequencer.
// ----------------------------------------------------------------------------
// The block holds up to DEPTH signed 32-bit values as a double-ended queue in
// a single RAM addressed from a front pointer. Each input transfer carries one
// operation and yields exactly one result transfer. Pushes and drops pass
// straight to the completion state and load their result from there. A
// search reads one entry per cycle through the RAM read port and stops at
// the first match or after the last held entry. A sort is an exchange sort run
// by the same read port and the single RAM write port: each outer pass loads
// its pivot, scans the rest and writes the pivot back. The block is back in
// idle, ready for the next item, once the result is loaded. One item is in
// work at a time; the input stalls while it runs, but a new item is taken
// while the previous result still waits in the output register. Entries are
// read only inside the held range, so the RAM needs no clearing.
// ----------------------------------------------------------------------------
module bounded_list_with_search_sort
    import bls_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  in_t  in_item,
    output logic out_valid,
    input  logic out_stall,
    output out_t out_item
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_LOAD,
        S_LOADW,
        S_SCAN,
        S_WBACK,
        S_DONE
    } state_t;

    // slot of a position counted from the front, wrapping at DEPTH
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CW-1:0] pos);
        logic [AW:0] sum;
        sum = {1'b0, base} + (AW+1)'(pos);
        if (sum >= (AW+1)'(DEPTH))
        begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    state_t                    state_reg, state_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [AW-1:0]             front_reg, front_next;
    logic signed [VALUE_W-1:0] key_reg, key_next;
    logic signed [VALUE_W-1:0] held_reg, held_next;
    logic [CW-1:0]             rd_pos_reg, rd_pos_next;
    logic                      cmp_valid_reg, cmp_valid_next;
    logic [CW-1:0]             cmp_pos_reg, cmp_pos_next;
    logic [AW-1:0]             cmp_slot_reg, cmp_slot_next;
    logic [CW-1:0]             i_reg, i_next;
    logic [STATUS_W-1:0]       status_reg, status_next;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic                      out_valid_reg, out_valid_next;
    out_t                      out_item_reg, out_item_next;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [VALUE_W-1:0] rd_data;

    logic [AW-1:0] front_dec;
    logic [AW-1:0] front_inc;
    logic [AW-1:0] slot_rd;
    logic [AW-1:0] slot_i;
    logic          full;

    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign slot_rd   = slot_of(front_reg, rd_pos_reg);
    assign slot_i    = slot_of(front_reg, i_reg);
    assign full      = (count_reg == CW'(DEPTH));

    bls_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        front_next     = front_reg;
        key_next       = key_reg;
        held_next      = held_reg;
        rd_pos_next    = rd_pos_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_pos_next   = cmp_pos_reg;
        cmp_slot_next  = cmp_slot_reg;
        i_next         = i_reg;
        status_next    = status_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;

        wr_en   = 1'b0;
        wr_addr = cmp_slot_reg;
        wr_data = held_reg;
        rd_en   = 1'b0;
        rd_addr = slot_rd;

        // drop the held result once the far side takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    status_next    = ST_OK;
                    pos_next       = '0;
                    key_next       = in_item.key;
                    rd_pos_next    = '0;
                    cmp_valid_next = 1'b0;
                    i_next         = '0;
                    state_next     = S_DONE;
                    unique case (in_item.mode)
                        MODE_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = front_dec;
                                wr_data    = in_item.value;
                                front_next = front_dec;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        MODE_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = slot_of(front_reg, count_reg);
                                wr_data    = in_item.value;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        MODE_DROP_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                front_next = front_inc;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        MODE_DROP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        MODE_SEARCH:
                        begin
                            state_next = S_SEARCH;
                        end
                        MODE_SORT:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                status_next = ST_SHORT;
                            end
                            else
                            begin
                                state_next = S_LOAD;
                            end
                        end
                        default:
                        begin
                            // unused codes: report ok, change nothing
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                // compare the entry read last cycle, issue the next read
                if (cmp_valid_reg && (rd_data == key_reg))
                begin
                    pos_next   = POS_W'(cmp_pos_reg + CW'(1));
                    state_next = S_DONE;
                end
                else if (rd_pos_reg < count_reg)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = slot_rd;
                    cmp_pos_next   = rd_pos_reg;
                    rd_pos_next    = rd_pos_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
            end

            S_LOAD:
            begin
                rd_en       = 1'b1;
                rd_addr     = slot_i;
                rd_pos_next = i_reg + 1'b1;
                state_next  = S_LOADW;
            end

            S_LOADW:
            begin
                // capture the pivot and start the scan behind it
                held_next      = $signed(rd_data);
                rd_en          = 1'b1;
                rd_addr        = slot_rd;
                cmp_slot_next  = slot_rd;
                rd_pos_next    = rd_pos_reg + 1'b1;
                cmp_valid_next = 1'b1;
                state_next     = S_SCAN;
            end

            S_SCAN:
            begin
                // exchange: the smaller value stays as pivot
                if (cmp_valid_reg && (held_reg > $signed(rd_data)))
                begin
                    wr_en     = 1'b1;
                    wr_addr   = cmp_slot_reg;
                    wr_data   = held_reg;
                    held_next = $signed(rd_data);
                end
                if (rd_pos_reg < count_reg)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = slot_rd;
                    cmp_slot_next  = slot_rd;
                    rd_pos_next    = rd_pos_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                    state_next     = S_WBACK;
                end
            end

            S_WBACK:
            begin
                wr_en   = 1'b1;
                wr_addr = slot_i;
                wr_data = held_reg;
                i_next  = i_reg + 1'b1;
                if (((CW+1)'(i_reg) + (CW+1)'(2)) < (CW+1)'(count_reg))
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // hold here until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next         = 1'b1;
                    out_item_next.status   = status_reg;
                    out_item_next.position = pos_reg;
                    out_item_next.count    = COUNT_W'(count_reg);
                    out_item_next.is_empty = (count_reg == '0);
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            front_reg     <= '0;
            key_reg       <= '0;
            held_reg      <= '0;
            rd_pos_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_pos_reg   <= '0;
            cmp_slot_reg  <= '0;
            i_reg         <= '0;
            status_reg    <= ST_OK;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            front_reg     <= front_next;
            key_reg       <= key_next;
            held_reg      <= held_next;
            rd_pos_reg    <= rd_pos_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_pos_reg   <= cmp_pos_next;
            cmp_slot_reg  <= cmp_slot_next;
            i_reg         <= i_next;
            status_reg    <= status_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
        end
    end

    // stall the input while an item is in work
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // an input transfer always starts work on the item
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("accepted item did not leave idle");

    // the count only moves on an input transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && !in_stall) |=> $stable(count_reg))
        else $error("count changed without an input transfer");

    // a result is only loaded from the completion state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result loaded outside completion");

    // the store never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

endmodule

[hw/rtl/bls_ram.sv]
// ----------------------------------------------------------------------------
// bls_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[verif/bounded_list_with_search_sort_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_list_with_search_sort_checker: result checker for the bounded list
// Watches both channels, keeps its own copy of the circular store, works out
// the result of every accepted operation and compares it with the block.
// ----------------------------------------------------------------------------
module bounded_list_with_search_sort_checker
    import bls_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_stall,
    input  in_t  in_item,
    input  logic out_valid,
    input  logic out_stall,
    input  out_t out_item,
    output int   fail_count,
    output int   pending,
    output int   checked
);

    localparam int REPORT_LIMIT = 10;

    logic signed [VALUE_W-1:0] list_mem [DEPTH];
    int unsigned               list_head;
    int unsigned               list_len;
    out_t                      awaited_results [$];

    function automatic int unsigned slot_at(input int unsigned pos);
        return (list_head + pos) % DEPTH;
    endfunction

    // Apply one operation to the shadow list and return its result.
    function automatic out_t apply_list_op(input in_t op);
        out_t                      res;
        logic signed [VALUE_W-1:0] swap_val;
        int unsigned               i;
        int unsigned               j;
        int unsigned               a;
        int unsigned               b;
        bit                        found;
        res        = '0;
        res.status = ST_OK;
        found      = 1'b0;
        case (op.mode)
            MODE_PUSH_FRONT:
                if (list_len >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    list_head           = (list_head + DEPTH - 1) % DEPTH;
                    list_mem[list_head] = op.value;
                    list_len++;
                end
            MODE_PUSH_BACK:
                if (list_len >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    list_mem[slot_at(list_len)] = op.value;
                    list_len++;
                end
            MODE_DROP_FRONT:
                if (list_len == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    list_head = (list_head + 1) % DEPTH;
                    list_len--;
                end
            MODE_DROP_BACK:
                if (list_len == 0)
                    res.status = ST_EMPTY;
                else
                    list_len--;
            MODE_SEARCH:
            begin
                res.status = ST_NOT_FOUND;
                for (i = 0; i < list_len && !found; i++)
                begin
                    if (list_mem[slot_at(i)] == op.key)
                    begin
                        found        = 1'b1;
                        res.status   = ST_OK;
                        res.position = POS_W'(i + 1);
                    end
                end
            end
            MODE_SORT:
                if (list_len < 2)
                    res.status = ST_SHORT;
                else
                begin
                    for (i = 0; i + 1 < list_len; i++)
                    begin
                        for (j = i + 1; j < list_len; j++)
                        begin
                            a = slot_at(i);
                            b = slot_at(j);
                            if (list_mem[a] > list_mem[b])
                            begin
                                swap_val    = list_mem[a];
                                list_mem[a] = list_mem[b];
                                list_mem[b] = swap_val;
                            end
                        end
                    end
                end
            default:
                ;
        endcase
        res.count    = COUNT_W'(list_len);
        res.is_empty = (list_len == 0);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input out_t want, input out_t got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("[%0t] %s: expected status=%0d position=%0d count=%0d empty=%0b, got status=%0d position=%0d count=%0d empty=%0b",
                     $time, what, want.status, want.position, want.count, want.is_empty,
                     got.status, got.position, got.count, got.is_empty);
    endtask

    task automatic compare_result(input out_t got);
        out_t want;
        checked++;
        if (awaited_results.size() == 0)
            report_mismatch("result with nothing outstanding", '0, got);
        else
        begin
            want = awaited_results.pop_front();
            if (got.status !== want.status || got.position !== want.position ||
                got.count !== want.count || got.is_empty !== want.is_empty)
                report_mismatch("result mismatch", want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_head = 0;
            list_len  = 0;
            awaited_results.delete();
            pending <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                awaited_results.push_back(apply_list_op(in_item));
            if (out_valid && !out_stall)
                compare_result(out_item);
            pending <= awaited_results.size();
        end
    end

endmodule

[verif/bounded_list_with_search_sort_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_list_with_search_sort_tb: top level of the bounded list testbench
// Drives directed and random deque operations into the block, idles both
// channels at random, holds the result side off once for a long stretch and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module bounded_list_with_search_sort_tb;
    import bls_pkg::*;

    localparam int     DEPTH        = DEPTH_DEFAULT;
    localparam int     RANDOM_ITEMS = 1800;
    localparam int     MAX_IDLE     = 19;
    localparam int     LONG_HOLD    = 400;
    localparam int     HOLD_AFTER   = 300;
    localparam int     DRAIN_CYCLES = 50;
    // worst case: every item a full sort with both idles,
    // taken several times over
    localparam longint CYCLE_LIMIT  = 20_000_000;

    // codes the block leaves unused; they must behave as a no-op
    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

    logic   clk;
    logic   rst_n      = 1'b0;
    logic   in_valid   = 1'b0;
    logic   in_stall;
    in_t    in_item    = '0;
    logic   out_valid;
    logic   out_stall;
    out_t   out_item;
    logic   stall_draw = 1'b0;
    logic   long_hold  = 1'b0;

    int     fail_count;
    int     pending;
    int     checked;
    longint cycle_count = 0;
    int     sent_count  = 0;
    int     taken_count = 0;
    int     push_ops    = 0;
    int     drop_ops    = 0;
    int     search_ops  = 0;
    int     sort_ops    = 0;
    int     spare_ops   = 0;
    bit     send_calm   = 1'b0;
    bit     take_calm   = 1'b0;

    // The receiver's own idling and the long hold-off are driven by separate
    // processes; merge them here so each flop sees one driver.
    assign out_stall = stall_draw | long_hold;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    bounded_list_with_search_sort #(
        .DEPTH(DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item)
    );

    bounded_list_with_search_sort_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .fail_count(fail_count),
        .pending   (pending),
        .checked   (checked)
    );

    // Mostly a small pool of values so that searches hit and sorts meet
    // duplicates; otherwise the extremes or a full-width random word.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int sel;
        int pool;
        sel  = $urandom_range(0, 99);
        pool = $urandom_range(0, 15);
        if (sel < 50)
            return pool - 8;
        else if (sel < 65)
        begin
            case (pool % 4)
                0:       return VAL_MAX;
                1:       return VAL_MIN;
                2:       return '0;
                default: return -1;
            endcase
        end
        else
            return $urandom;
    endfunction

    // Offer one operation and hold it until the block takes the transfer.
    // Entered and left at a falling edge; valid is only dropped when a gap
    // is drawn, so back-to-back items keep it high.
    task automatic send_op(input logic [MODE_W-1:0] mode,
                           input logic signed [VALUE_W-1:0] value,
                           input logic signed [VALUE_W-1:0] key);
        in_t op;
        int  gap;
        op.mode  = mode;
        op.value = value;
        op.key   = key;
        gap      = send_calm ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item  <= op;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sent_count++;
        case (mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: push_ops++;
            MODE_DROP_FRONT, MODE_DROP_BACK: drop_ops++;
            MODE_SEARCH:                     search_ops++;
            MODE_SORT:                       sort_ops++;
            default:                         spare_ops++;
        endcase
        @(negedge clk);
    endtask

    // One operation from the general mix; value and key are always random
    // so that ignored fields still toggle.
    task automatic send_mixed_op();
        int                        pick;
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] key;
        pick = $urandom_range(0, 99);
        if (pick < 22)
            mode = MODE_PUSH_FRONT;
        else if (pick < 44)
            mode = MODE_PUSH_BACK;
        else if (pick < 56)
            mode = MODE_DROP_FRONT;
        else if (pick < 68)
            mode = MODE_DROP_BACK;
        else if (pick < 90)
            mode = MODE_SEARCH;
        else if (pick < 96)
            mode = MODE_SORT;
        else
            mode = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
        key = ($urandom_range(0, 9) < 7) ? pick_value() : $urandom;
        send_op(mode, pick_value(), key);
    endtask

    // Stimulus: reset, a directed opening, then random sequences.
    initial
    begin : stimulus
        int start_count;
        int run;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: everything on an empty list first, then the value
        // extremes with a front push that wraps the head pointer, searches
        // with and without a match and a sort with both signs.
        send_op(MODE_DROP_FRONT, '0, '0);
        send_op(MODE_DROP_BACK, '0, '0);
        send_op(MODE_SEARCH, '0, '0);
        send_op(MODE_SORT, '0, '0);
        send_op(MODE_SPARE_A, VAL_MAX, VAL_MIN);
        send_op(MODE_SPARE_B, VAL_MIN, VAL_MAX);
        send_op(MODE_PUSH_BACK, VAL_MAX, '0);
        send_op(MODE_SORT, '0, '0);
        send_op(MODE_PUSH_FRONT, VAL_MIN, '0);
        send_op(MODE_PUSH_BACK, -1, '0);
        send_op(MODE_PUSH_FRONT, '0, '0);
        send_op(MODE_PUSH_BACK, 1, '0);
        send_op(MODE_SEARCH, '0, -1);
        send_op(MODE_SEARCH, '0, 5);
        send_op(MODE_SORT, '0, '0);
        send_op(MODE_SEARCH, '0, VAL_MAX);
        send_op(MODE_SEARCH, '0, VAL_MIN);
        send_op(MODE_PUSH_FRONT, 1, '0);
        send_op(MODE_SEARCH, '0, 1);
        send_op(MODE_DROP_FRONT, '0, '0);
        send_op(MODE_DROP_BACK, '0, '0);
        send_op(MODE_DROP_BACK, '0, '0);
        send_op(MODE_DROP_FRONT, '0, '0);
        send_op(MODE_DROP_FRONT, '0, '0);
        send_op(MODE_DROP_BACK, '0, '0);
        send_op(MODE_DROP_BACK, '0, '0);

        // Random: mixed runs, with the odd run that fills the list past
        // full or drains it past empty so both edges are visited often.
        start_count = sent_count;
        while (sent_count - start_count < RANDOM_ITEMS)
        begin
            send_calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 15))
                0:
                begin
                    run = DEPTH + $urandom_range(1, 3);
                    repeat (run)
                        send_op($urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK,
                                pick_value(), pick_value());
                end
                1:
                begin
                    run = DEPTH + $urandom_range(1, 3);
                    repeat (run)
                        send_op($urandom_range(0, 1) ? MODE_DROP_FRONT : MODE_DROP_BACK,
                                pick_value(), pick_value());
                end
                default:
                begin
                    run = $urandom_range(8, 24);
                    repeat (run)
                        send_mixed_op();
                end
            endcase
        end
        in_valid <= 1'b0;

        // Wait for the last results, then linger to catch any stray transfer.
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d operations: %0d pushes, %0d drops, %0d searches,",
                 sent_count, push_ops, drop_ops, search_ops);
        $display("  %0d sorts, %0d spare codes", sort_ops, spare_ops);
        $display("compared %0d results with %0d mismatches; one receiver hold of %0d cycles",
                 checked, fail_count, LONG_HOLD);
        if (fail_count == 0)
            $display("bounded_list_with_search_sort_tb OK");
        else
            $display("bounded_list_with_search_sort_tb NOT OK");
        $finish;
    end

    // Receiver: draw an idle stretch after every transfer, stall through it,
    // then take the next result. Calm runs with no idling come and go.
    initial
    begin : result_side
        int idle;
        @(posedge rst_n);
        forever
        begin
            if (taken_count % 32 == 0)
                take_calm = ($urandom_range(0, 3) == 0);
            idle = take_calm ? 0 : $urandom_range(0, MAX_IDLE);
            @(negedge clk);
            if (idle > 0)
            begin
                stall_draw <= 1'b1;
                repeat (idle) @(negedge clk);
                stall_draw <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
            taken_count++;
        end
    end

    // Hold the result side off for a long stretch once traffic is under way,
    // so the output register and the working slot fill and the input stalls.
    initial
    begin : long_hold_off
        wait (rst_n && sent_count >= HOLD_AFTER);
        @(negedge clk);
        long_hold <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold <= 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("bounded_list_with_search_sort_tb NOT OK");
            $finish;
        end
    end

endmodule
